// ----- design/glzw_pkg.sv -----
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_MORE  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam int          ENTRY_W   = 33;
    localparam logic [3:0]  MAX_WIDTH = 4'd12;
    localparam logic [3:0]  MIN_RESET = 4'd8;

    // decoder phase
    typedef enum logic [6:0] {
        PH_FRESH       = 7'b0000001,
        PH_NORM_PROV   = 7'b0000010,
        PH_NORM_FULL   = 7'b0000100,
        PH_WALK_PROV   = 7'b0001000,
        PH_WALK_NOPROV = 7'b0010000,
        PH_STOPPED     = 7'b0100000,
        PH_ERROR       = 7'b1000000
    } t_phase;

    // one string table entry
    typedef struct packed {
        logic [12:0] len;
        logic [7:0]  suffix;
        logic [11:0] prefix;
    } t_entry;

    // bit buffer control
    typedef struct packed {
        logic       clr;
        logic       push;
        logic [7:0] data;
        logic       pop;
        logic [3:0] width;
    } t_bb_ctl;

    // minimum code size clamped to 2..8
    function automatic logic [3:0] f_eff_min(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m < 4'd2) r = 4'd2;
        if (m > 4'd8) r = 4'd8;
        return r;
    endfunction

endpackage

// ----- design/gif_lzw_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// GIF LZW decoder: strips sub-block lengths, unpacks codes, walks the string
// table and returns one result per pull item: a pixel, last pixel of a string first, or a status.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  tuser cmd, tdata data_byte
// m         out  o_m_tvalid/i_m_tready  tuser kind, tdata index/offset, tlast
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_data min_code_size
//
// a push item is taken in the idle state; a refused push, a stop or an error
// pull goes from there to the output load. a decoding pull takes codes from
// the bit buffer in the decode state or finds too few bits; a string pixel
// then passes accept, table read, emit and output load, and a table write
// on the pixel that adds a table entry. reset and a config write restart the
// decoder at once; no clearing pass, root entries come from the code value.
// a result waits while the output register is full, and the input stalls meanwhile.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int OFFSET_BITS   = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // pixel_index [7:0], pixel_offset [31:8]
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data   // min_code_size
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [12:0] TE13 = 13'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_EMIT   = 6'b001000,
        S_FIN    = 6'b010000,
        S_PUT    = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [3:0]             r_min;
    logic [12:0]            r_nfc, n_nfc;
    logic [3:0]             r_width, n_width;
    logic [7:0]             r_sub, n_sub;
    logic [AW-1:0]          r_prev, n_prev;
    logic [AW-1:0]          r_walk, n_walk;
    logic [OFFSET_BITS-1:0] r_base, n_base;
    logic                   r_full, n_full;
    logic                   r_grow, n_grow;
    glzw_pkg::t_phase       r_phase, n_phase;
    logic                   r_done, n_done;
    logic                   r_first, n_first;
    logic [12:0]            r_cur_len, n_cur_len;
    logic [AW-1:0]          r_prov_prefix, n_prov_prefix;
    logic [12:0]            r_prov_len, n_prov_len;
    glzw_pkg::t_entry       r_new, n_new;
    logic [AW-1:0]          r_new_addr, n_new_addr;
    logic [1:0]             r_res_kind, n_res_kind;
    logic [7:0]             r_res_idx, n_res_idx;
    logic [OFFSET_BITS-1:0] r_res_off, n_res_off;
    logic                   r_res_last, n_res_last;
    logic                   r_ov, n_ov;
    logic [1:0]             r_okind, n_okind;
    logic [7:0]             r_oidx, n_oidx;
    logic [OFFSET_BITS-1:0] r_ooff, n_ooff;
    logic                   r_olast, n_olast;

    logic                   w_restart;
    logic [3:0]             w_new_min, w_m, w_rm;
    logic [12:0]            w_clear, w_rclear;
    logic                   w_in_acc;
    glzw_pkg::t_bb_ctl      w_bb;
    logic [11:0]            w_code;
    logic [12:0]            w_code13;
    logic [4:0]             w_held;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    glzw_pkg::t_entry       w_wdata, w_rd, w_e;
    logic [12:0]            w_len, w_nfc1;
    logic [OFFSET_BITS+23:0] w_off_ext;

    assign w_restart  = !i_rst_n || i_cfg_valid;
    assign w_new_min  = !i_rst_n ? glzw_pkg::MIN_RESET : i_cfg_data;
    assign w_m        = glzw_pkg::f_eff_min(r_min);
    assign w_rm       = glzw_pkg::f_eff_min(w_new_min);
    assign w_clear    = 13'd1 << w_m;
    assign w_rclear   = 13'd1 << w_rm;
    assign o_cfg_ready = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_code13   = {1'b0, w_code};

    glzw_bitbuf u_bitbuf (
        .i_clk       (i_clk),
        .i_ctl       (w_bb),
        .o_code      (w_code),
        .o_bits_held (w_held)
    );

    glzw_ram #(.WIDTH(glzw_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_walk),
        .o_rdata (w_rd)
    );

    // root entries come from the code itself
    always_comb begin
        w_e = w_rd;
        if ({{(13-AW){1'b0}}, r_walk} < w_clear) begin
            w_e.len    = 13'd1;
            w_e.suffix = r_walk[7:0];
            w_e.prefix = '0;
        end
    end
    assign w_len  = r_first ? w_e.len : r_cur_len;
    assign w_nfc1 = r_nfc + 13'd1;

    // sequencer
    always_comb begin
        n_state = r_state;   n_nfc = r_nfc;       n_width = r_width;
        n_sub = r_sub;       n_prev = r_prev;     n_walk = r_walk;
        n_base = r_base;     n_full = r_full;     n_grow = r_grow;
        n_phase = r_phase;   n_done = r_done;     n_first = r_first;
        n_cur_len = r_cur_len;
        n_prov_prefix = r_prov_prefix;            n_prov_len = r_prov_len;
        n_new = r_new;       n_new_addr = r_new_addr;
        n_res_kind = r_res_kind;  n_res_idx = r_res_idx;
        n_res_off = r_res_off;    n_res_last = r_res_last;
        n_ov = r_ov;         n_okind = r_okind;   n_oidx = r_oidx;
        n_ooff = r_ooff;     n_olast = r_olast;
        w_bb = '0;
        w_bb.width = r_width;
        w_bb.data  = i_s_tdata;
        w_we = 1'b0;
        w_waddr = r_new_addr;
        w_wdata = r_new;

        if (r_ov && i_m_tready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_kind = glzw_pkg::KIND_ERROR;
                    n_res_idx  = '0;
                    n_res_off  = '0;
                    n_res_last = 1'b0;
                    if (i_s_tuser == glzw_pkg::CMD_PULL) begin
                        case (r_phase)
                            glzw_pkg::PH_ERROR:   n_state = S_PUT;
                            glzw_pkg::PH_STOPPED: begin
                                n_res_kind = glzw_pkg::KIND_STOP;
                                n_state    = S_PUT;
                            end
                            glzw_pkg::PH_WALK_PROV,
                            glzw_pkg::PH_WALK_NOPROV: begin
                                n_first = 1'b0;
                                n_state = S_READ;
                            end
                            default: n_state = S_DECODE;
                        endcase
                    end else if (r_done) begin
                        n_state = S_PUT;
                    end else if (r_sub == 8'd0) begin
                        if (i_s_tdata == 8'd0) n_done = 1'b1;
                        else n_sub = i_s_tdata;
                    end else if (r_phase == glzw_pkg::PH_STOPPED ||
                                 r_phase == glzw_pkg::PH_ERROR) begin
                        n_sub = r_sub - 8'd1;
                    end else if (w_held > 5'd16) begin
                        n_state = S_PUT;
                    end else begin
                        w_bb.push = 1'b1;
                        n_sub = r_sub - 8'd1;
                    end
                end
            end
            S_DECODE: begin
                if (w_held < {1'b0, r_width}) begin
                    n_res_kind = r_done ? glzw_pkg::KIND_ERROR : glzw_pkg::KIND_MORE;
                    if (r_done) n_phase = glzw_pkg::PH_ERROR;
                    n_state = S_PUT;
                end else begin
                    w_bb.pop = 1'b1;
                    if (w_code13 == w_clear) begin
                        // clear code: restart the table and keep reading
                        n_nfc   = w_clear + 13'd2;
                        n_width = w_m + 4'd1;
                        n_full  = 1'b0;
                        n_grow  = 1'b0;
                        n_phase = glzw_pkg::PH_FRESH;
                    end else if (w_code13 == w_clear + 13'd1) begin
                        n_phase    = glzw_pkg::PH_STOPPED;
                        n_res_kind = glzw_pkg::KIND_STOP;
                        n_state    = S_PUT;
                    end else begin
                        if (r_grow) begin
                            n_grow = 1'b0;
                            if (r_width < glzw_pkg::MAX_WIDTH) n_width = r_width + 4'd1;
                        end
                        if (w_code13 >= r_nfc || w_code13 >= TE13) begin
                            n_phase = glzw_pkg::PH_ERROR;
                            n_state = S_PUT;
                        end else begin
                            n_prev  = w_code[AW-1:0];
                            n_walk  = w_code[AW-1:0];
                            n_phase = (r_phase == glzw_pkg::PH_NORM_PROV) ?
                                      glzw_pkg::PH_WALK_PROV : glzw_pkg::PH_WALK_NOPROV;
                            n_first = 1'b1;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: n_state = S_EMIT;
            S_EMIT: begin
                // emit one pixel of the string
                n_first    = 1'b0;
                n_cur_len  = w_len;
                n_res_kind = glzw_pkg::KIND_PIXEL;
                n_res_idx  = w_e.suffix;
                n_res_off  = r_base + OFFSET_BITS'(w_e.len) - OFFSET_BITS'(1);
                n_res_last = (w_e.len <= 13'd1);
                n_state    = S_PUT;
                if (w_e.len <= 13'd1) begin
                    // string done: fix provisional suffix, add the next entry
                    if (r_phase == glzw_pkg::PH_WALK_PROV && r_nfc <= TE13) begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_nfc - 13'd1);
                        w_wdata = {r_prov_len, w_e.suffix, 12'(r_prov_prefix)};
                    end
                    n_base = r_base + OFFSET_BITS'(w_len);
                    if (!r_full && r_nfc < TE13) begin
                        n_new         = {w_len + 13'd1, w_e.suffix, 12'(r_prev)};
                        n_new_addr    = AW'(r_nfc);
                        n_prov_prefix = r_prev;
                        n_prov_len    = w_len + 13'd1;
                        n_nfc         = w_nfc1;
                        if (w_nfc1 >= TE13) n_full = 1'b1;
                        else if ((w_nfc1 & (w_nfc1 - 13'd1)) == 13'd0) n_grow = 1'b1;
                        n_phase = glzw_pkg::PH_NORM_PROV;
                        n_state = S_FIN;
                    end else begin
                        n_full  = 1'b1;
                        n_phase = glzw_pkg::PH_NORM_FULL;
                    end
                end else begin
                    n_walk = w_e.prefix[AW-1:0];
                end
            end
            S_FIN: begin
                w_we    = 1'b1;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_okind = r_res_kind;
                    n_oidx  = r_res_idx;
                    n_ooff  = r_res_off;
                    n_olast = r_res_last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_restart) w_bb.clr = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (w_restart) begin
            r_state <= S_IDLE;
            r_min   <= w_new_min;
            r_nfc   <= w_rclear + 13'd2;
            r_width <= w_rm + 4'd1;
            r_sub   <= '0;
            r_prev  <= '0;
            r_walk  <= '0;
            r_base  <= '0;
            r_full  <= 1'b0;
            r_grow  <= 1'b0;
            r_phase <= glzw_pkg::PH_FRESH;
            r_done  <= 1'b0;
            r_first <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nfc   <= n_nfc;
            r_width <= n_width;
            r_sub   <= n_sub;
            r_prev  <= n_prev;
            r_walk  <= n_walk;
            r_base  <= n_base;
            r_full  <= n_full;
            r_grow  <= n_grow;
            r_phase <= n_phase;
            r_done  <= n_done;
            r_first <= n_first;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_len     <= n_cur_len;
        r_prov_prefix <= n_prov_prefix;
        r_prov_len    <= n_prov_len;
        r_new         <= n_new;
        r_new_addr    <= n_new_addr;
        r_res_kind    <= n_res_kind;
        r_res_idx     <= n_res_idx;
        r_res_off     <= n_res_off;
        r_res_last    <= n_res_last;
        r_okind       <= n_okind;
        r_oidx        <= n_oidx;
        r_ooff        <= n_ooff;
        r_olast       <= n_olast;
    end

    // output port
    assign w_off_ext  = {24'd0, r_ooff};
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {w_off_ext[23:0], r_oidx};
    assign o_m_tlast  = r_olast;
endmodule

// ----- design/glzw_ram.sv -----
// ----------------------------------------------------------------------------
// glzw_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/glzw_bitbuf.sv -----
// ----------------------------------------------------------------------------
// glzw_bitbuf
// LSB-first bit buffer: appends bytes and hands out variable width codes.
// ----------------------------------------------------------------------------
module glzw_bitbuf (
    input  logic             i_clk,
    input  glzw_pkg::t_bb_ctl i_ctl,
    output logic [11:0]      o_code,
    output logic [4:0]       o_bits_held
);
    logic [23:0] r_buf, n_buf;
    logic [4:0]  r_held, n_held;
    logic [11:0] w_mask;

    // code extract
    assign w_mask      = ~(12'hFFF << i_ctl.width);
    assign o_code      = r_buf[11:0] & w_mask;
    assign o_bits_held = r_held;

    // append or shift out
    always_comb begin
        n_buf  = r_buf;
        n_held = r_held;
        if (i_ctl.push) begin
            n_buf  = r_buf | ({16'd0, i_ctl.data} << r_held);
            n_held = r_held + 5'd8;
        end else if (i_ctl.pop) begin
            n_buf  = r_buf >> i_ctl.width;
            n_held = r_held - {1'b0, i_ctl.width};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_buf  <= '0;
            r_held <= '0;
        end else begin
            r_buf  <= n_buf;
            r_held <= n_held;
        end
    end
endmodule

// ----- tb/tb_gif_lzw_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_gif_lzw_decoder_unit
// Self-checking bench for the GIF LZW decoder. A small LZW encoder builds code
// streams (KwKwK strings, clears, stops, bad codes), packs them into
// sub-blocks and pushes them with pulls mixed in. A decoder model in the
// bench predicts every pixel, status and error item, checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gif_lzw_decoder_unit;

    localparam int TBL_N    = 4096;
    localparam int OFF_MASK = 24'hFFFFFF;

    // expected output item
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  idx;
        logic [23:0] off;
        logic        lst;
    } t_pixel_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // data_byte
    logic        i_s_tuser;    // cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;    // pixel_index [7:0], pixel_offset [31:8]
    logic [1:0]  o_m_tuser;    // kind
    logic        o_m_tlast;    // last
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;   // min_code_size

    gif_lzw_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // decoder model state
    logic [11:0] tbl_prefix [TBL_N];
    logic [7:0]  tbl_suffix [TBL_N];
    logic [12:0] tbl_len    [TBL_N];
    logic [3:0]  mdl_min;
    int          mdl_nfc, mdl_width, mdl_buf, mdl_bits, mdl_left;
    int          mdl_prev, mdl_walk, mdl_base;
    bit          mdl_full, mdl_grow, mdl_done;
    glzw_pkg::t_phase mdl_phase;

    t_pixel_exp  pixel_q [$];
    int          n_errors;
    int          n_items;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    // encoder output
    int          forced_codes [$];
    logic [7:0]  img_bytes [$];
    bit          img_is_data [$];

    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tb_gif_lzw_decoder_unit NOT OK");
        $finish;
    end

    function automatic int eff_min_size(logic [3:0] m);
        if (m < 2) return 2;
        if (m > 8) return 8;
        return m;
    endfunction

    function automatic void table_restart();
        mdl_nfc   = (1 << eff_min_size(mdl_min)) + 2;
        mdl_width = eff_min_size(mdl_min) + 1;
        mdl_full  = 0;
        mdl_grow  = 0;
        mdl_phase = glzw_pkg::PH_FRESH;
    endfunction

    function automatic void model_restart(logic [3:0] m);
        mdl_min = m;
        for (int k = 0; k < TBL_N; k++) begin
            tbl_prefix[k] = '0;
            tbl_suffix[k] = (k < (1 << eff_min_size(m))) ? k[7:0] : 8'd0;
            tbl_len[k]    = (k < (1 << eff_min_size(m))) ? 13'd1 : 13'd0;
        end
        table_restart();
        mdl_buf = 0; mdl_bits = 0; mdl_left = 0;
        mdl_prev = 0; mdl_walk = 0; mdl_base = 0;
        mdl_done = 0;
    endfunction

    function automatic void expect_item(logic [1:0] k, logic [7:0] idx, int off, logic lst);
        t_pixel_exp e;
        e.kind = k; e.idx = idx; e.off = off[23:0]; e.lst = lst;
        pixel_q.push_back(e);
    endfunction

    function automatic void expect_status(logic [1:0] k);
        expect_item(k, 8'd0, 0, 1'b0);
    endfunction

    // close a code: complete the provisional entry and add the next one
    function automatic void close_code(logic [7:0] first);
        int cur, l;
        cur = mdl_prev % TBL_N;
        if (mdl_phase == glzw_pkg::PH_WALK_PROV && mdl_nfc > 0 && mdl_nfc <= TBL_N)
            tbl_suffix[mdl_nfc - 1] = first;
        l = tbl_len[cur];
        mdl_base = (mdl_base + l) & OFF_MASK;
        if (!mdl_full && mdl_nfc < TBL_N) begin
            tbl_prefix[mdl_nfc] = cur[11:0];
            tbl_suffix[mdl_nfc] = first;
            tbl_len[mdl_nfc]    = 13'(l + 1);
            mdl_nfc++;
            if (mdl_nfc >= TBL_N) mdl_full = 1;
            else if ((mdl_nfc & (mdl_nfc - 1)) == 0) mdl_grow = 1;
            mdl_phase = glzw_pkg::PH_NORM_PROV;
        end else begin
            mdl_full  = 1;
            mdl_phase = glzw_pkg::PH_NORM_FULL;
        end
    endfunction

    function automatic void walk_one();
        int w, off;
        w   = mdl_walk % TBL_N;
        off = (mdl_base + int'(tbl_len[w]) - 1) & OFF_MASK;
        if (tbl_len[w] <= 1) begin
            expect_item(glzw_pkg::KIND_PIXEL, tbl_suffix[w], off, 1'b1);
            close_code(tbl_suffix[w]);
        end else begin
            expect_item(glzw_pkg::KIND_PIXEL, tbl_suffix[w], off, 1'b0);
            mdl_walk = tbl_prefix[w];
        end
    endfunction

    function automatic void decode_pull();
        int clr, code;
        clr = 1 << eff_min_size(mdl_min);
        if (mdl_phase == glzw_pkg::PH_ERROR) begin
            expect_status(glzw_pkg::KIND_ERROR);
            return;
        end
        if (mdl_phase == glzw_pkg::PH_STOPPED) begin
            expect_status(glzw_pkg::KIND_STOP);
            return;
        end
        if (mdl_phase == glzw_pkg::PH_WALK_PROV || mdl_phase == glzw_pkg::PH_WALK_NOPROV) begin
            walk_one();
            return;
        end
        forever begin
            if (mdl_bits < mdl_width) begin
                if (mdl_done) begin
                    mdl_phase = glzw_pkg::PH_ERROR;
                    expect_status(glzw_pkg::KIND_ERROR);
                end else begin
                    expect_status(glzw_pkg::KIND_MORE);
                end
                return;
            end
            code = mdl_buf & ((1 << mdl_width) - 1);
            mdl_buf  = mdl_buf >> mdl_width;
            mdl_bits = mdl_bits - mdl_width;
            if (code == clr) begin
                table_restart();
                continue;
            end
            if (code == clr + 1) begin
                mdl_phase = glzw_pkg::PH_STOPPED;
                expect_status(glzw_pkg::KIND_STOP);
                return;
            end
            if (mdl_grow) begin
                mdl_grow = 0;
                if (mdl_width < 12) mdl_width++;
            end
            if (code >= mdl_nfc || code >= TBL_N) begin
                mdl_phase = glzw_pkg::PH_ERROR;
                expect_status(glzw_pkg::KIND_ERROR);
                return;
            end
            mdl_prev  = code;
            mdl_walk  = code;
            mdl_phase = (mdl_phase == glzw_pkg::PH_NORM_PROV) ?
                        glzw_pkg::PH_WALK_PROV : glzw_pkg::PH_WALK_NOPROV;
            walk_one();
            return;
        end
    endfunction

    function automatic void decode_item(logic cmd, logic [7:0] b);
        if (cmd == glzw_pkg::CMD_PULL) begin
            decode_pull();
            return;
        end
        if (mdl_done) begin
            expect_status(glzw_pkg::KIND_ERROR);
            return;
        end
        if (mdl_left == 0) begin
            if (b == 0) mdl_done = 1;
            else mdl_left = b;
            return;
        end
        if (mdl_phase == glzw_pkg::PH_STOPPED || mdl_phase == glzw_pkg::PH_ERROR) begin
            mdl_left--;
            return;
        end
        if (mdl_bits > 16) begin
            expect_status(glzw_pkg::KIND_ERROR);
            return;
        end
        mdl_buf  = (mdl_buf | (int'(b) << mdl_bits)) & OFF_MASK;
        mdl_bits = mdl_bits + 8;
        mdl_left--;
    endfunction

    // result checker and receiver ready
    always @(posedge i_clk) begin
        t_pixel_exp e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item kind %0d tdata %h", $time, o_m_tuser, o_m_tdata);
            end else begin
                e = pixel_q.pop_front();
                if (o_m_tuser !== e.kind || o_m_tdata[7:0] !== e.idx
                        || o_m_tdata[31:8] !== e.off || o_m_tlast !== e.lst) begin
                    n_errors++;
                    $display("%0t: mismatch exp kind %0d idx %0d off %0d last %0d",
                             $time, e.kind, e.idx, e.off, e.lst);
                    $display("%0t:          got kind %0d idx %0d off %0d last %0d",
                             $time, o_m_tuser, o_m_tdata[7:0], o_m_tdata[31:8], o_m_tlast);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic cmd, logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        decode_item(cmd, b);
        n_items++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_min_size(logic [3:0] m);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_restart(m);
    endtask

    // build a code stream for the current size; ending 0 stop, 1 none, 2 bad code
    task automatic build_image(int ncodes, int ending, int root_pct);
        int          clr, c, nfc, wid, acc, nacc, r, n, pos;
        bit          grow, fresh, full, stopped;
        logic [7:0]  payload [$];
        clr = 1 << eff_min_size(mdl_min);
        nfc = clr + 2; wid = eff_min_size(mdl_min) + 1;
        grow = 0; fresh = 1; full = 0; stopped = 0;
        acc = 0; nacc = 0;
        for (int k = 0; k < ncodes + 1 && !stopped; k++) begin
            if (forced_codes.size() != 0) begin
                c = forced_codes.pop_front();
            end else if (k == ncodes) begin
                if (ending == 1) break;
                c = clr + 1;
                if (ending == 2 && ((1 << wid) - 1) >= nfc) c = (1 << wid) - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (!fresh && r < 3) c = clr;
                else if (fresh || r < root_pct) c = $urandom_range(0, clr - 1);
                else if (r < root_pct + (100 - root_pct) / 2) c = nfc - 1;
                else c = $urandom_range(clr + 2, nfc - 1);
            end
            acc = acc | (c << nacc);
            nacc = nacc + wid;
            while (nacc >= 8) begin
                payload.push_back(acc[7:0]);
                acc = acc >> 8;
                nacc = nacc - 8;
            end
            // track the decoder's table and width
            if (c == clr) begin
                nfc = clr + 2; wid = eff_min_size(mdl_min) + 1;
                grow = 0; fresh = 1; full = 0;
            end else if (c == clr + 1 || c >= nfc) begin
                stopped = 1;
            end else begin
                if (grow) begin
                    grow = 0;
                    if (wid < 12) wid++;
                end
                if (!full && nfc < TBL_N) begin
                    nfc++;
                    if (nfc >= TBL_N) full = 1;
                    else if ((nfc & (nfc - 1)) == 0) grow = 1;
                end else begin
                    full = 1;
                end
                fresh = 0;
            end
        end
        if (nacc > 0) payload.push_back(acc[7:0]);
        // data past the stop code is counted off and dropped
        if (ending == 0) repeat (2) payload.push_back(8'($urandom_range(0, 255)));
        img_bytes.delete();
        img_is_data.delete();
        pos = 0;
        while (pos < payload.size()) begin
            n = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 12);
            if (n > payload.size() - pos) n = payload.size() - pos;
            img_bytes.push_back(n[7:0]);
            img_is_data.push_back(0);
            repeat (n) begin
                img_bytes.push_back(payload[pos]);
                img_is_data.push_back(1);
                pos++;
            end
        end
        img_bytes.push_back(8'd0);
        img_is_data.push_back(0);
    endtask

    // push the built stream with pulls mixed in, then pull until it ends
    task automatic stream_image(int pull_pct);
        int guard;
        for (int i = 0; i < img_bytes.size(); i++) begin
            if (img_is_data[i])
                while (mdl_bits > 16 && mdl_phase != glzw_pkg::PH_STOPPED
                       && mdl_phase != glzw_pkg::PH_ERROR)
                    send_item(glzw_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < pull_pct)
                send_item(glzw_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
            send_item(glzw_pkg::CMD_PUSH, img_bytes[i]);
        end
        guard = 0;
        while (mdl_phase != glzw_pkg::PH_STOPPED && mdl_phase != glzw_pkg::PH_ERROR
               && guard < 20000) begin
            send_item(glzw_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
            guard++;
        end
        repeat (2) send_item(glzw_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
    endtask

    // roots at both ends, KwKwK string, clear, stop, bytes after the end
    task automatic test_directed_codes();
        forced_codes = '{0, 258, 255, 256, 7, 258, 257};
        build_image(8, 0, 50);
        stream_image(0);
        send_item(glzw_pkg::CMD_PUSH, 8'hFF);
        send_item(glzw_pkg::CMD_PULL, 8'h00);
        wait_drained();
    endtask

    // a data byte pushed with more than 16 bits held is refused
    task automatic test_buffer_full();
        write_min_size(4'd8);
        send_item(glzw_pkg::CMD_PUSH, 8'd5);
        repeat (4) send_item(glzw_pkg::CMD_PUSH, 8'($urandom_range(0, 255)));
        repeat (3) send_item(glzw_pkg::CMD_PULL, 8'h00);
        send_item(glzw_pkg::CMD_PUSH, 8'h00);
        send_item(glzw_pkg::CMD_PUSH, 8'h00);
        send_item(glzw_pkg::CMD_PUSH, 8'h00);
        repeat (3) send_item(glzw_pkg::CMD_PULL, 8'h00);
        wait_drained();
    endtask

    // code past the table, and a stream that ends without a stop code
    task automatic test_bad_codes();
        write_min_size(4'd3);
        build_image(10, 2, 40);
        stream_image(30);
        write_min_size(4'd5);
        build_image(10, 1, 40);
        stream_image(30);
        wait_drained();
    endtask

    // sizes outside 2..8 are clamped
    task automatic test_clamped_sizes();
        logic [3:0] sizes [4];
        sizes = '{4'd0, 4'd1, 4'd9, 4'd15};
        foreach (sizes[k]) begin
            write_min_size(sizes[k]);
            build_image(8, 0, 50);
            stream_image(25);
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        write_min_size(4'd6);
        hold_cycles = 400;
        build_image(20, 0, 50);
        stream_image(40);
        wait_drained();
    endtask

    task automatic test_random_images();
        int start;
        int s_pct [3];
        int r_pct [3];
        s_pct = '{18, 51, 0};
        r_pct = '{51, 18, 0};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = s_pct[p];
            recv_idle_pct = r_pct[p];
            start = n_items;
            while (n_items - start < 150) begin
                write_min_size(4'($urandom_range(2, 8)));
                build_image($urandom_range(3, 30), ($urandom_range(0, 9) == 0) ? 2 :
                            ($urandom_range(0, 9) == 0) ? 1 : 0, $urandom_range(30, 80));
                stream_image($urandom_range(5, 50));
            end
        end
        wait_drained();
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = glzw_pkg::CMD_PUSH;
        i_m_tready = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        n_errors = 0;
        n_items = 0;
        hold_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 51;
        model_restart(glzw_pkg::MIN_RESET);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_codes();
        test_buffer_full();
        test_bad_codes();
        test_clamped_sizes();
        test_backpressure();
        test_random_images();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && pixel_q.size() == 0) begin
            $display("tb_gif_lzw_decoder_unit OK");
        end else begin
            $display("tb_gif_lzw_decoder_unit NOT OK");
        end
        $finish;
    end

endmodule
